// File: design/srcf_pkg.sv
// shared types and constants for the serial receive command fifo
// no dependencies; imported by every module of the block but srcf_queue
package srcf_pkg;

	localparam int FIFO_DEPTH_DEF = 256;
	localparam int CHUNK_LEN_DEF  = 16;
	localparam int Q_DEPTH        = 2;
	localparam int CFG_ADDR_W     = 5;

	localparam logic [2:0] FN_RECEIVE     = 3'd0;
	localparam logic [2:0] FN_PROTO_READ  = 3'd1;
	localparam logic [2:0] FN_RASTER_READ = 3'd2;
	localparam logic [2:0] FN_CONSUME     = 3'd3;
	localparam logic [2:0] FN_STOP_MODES  = 3'd4;

	localparam logic [1:0] STOP_NONE     = 2'd0;
	localparam logic [1:0] STOP_REQ      = 2'd1;
	localparam logic [1:0] STOP_INVALID  = 2'd2;
	localparam logic [1:0] STOP_OVERFLOW = 2'd3;

	localparam logic [7:0] RASTER_ZERO = 8'd128;

	localparam logic [3:0] RST_STOP_CODE    = 4'd1;
	localparam logic [3:0] RST_RESUME_CODE  = 4'd2;
	localparam logic [3:0] RST_STATUS_CODE  = 4'd3;
	localparam logic [3:0] RST_SSTATUS_CODE = 4'd4;
	localparam logic [6:0] RST_RSTART_CODE  = 7'd16;
	localparam logic [6:0] RST_REND_CODE    = 7'd17;

	typedef enum logic [2:0] {
		REG_STOP    = 3'd0,
		REG_RESUME  = 3'd1,
		REG_STATUS  = 3'd2,
		REG_SSTATUS = 3'd3,
		REG_RSTART  = 3'd4,
		REG_REND    = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_STOP,
		OP_RESUME,
		OP_STATUS,
		OP_SSTATUS,
		OP_INVALID,
		OP_WRITE,
		OP_PROTO_READ,
		OP_RASTER_READ,
		OP_CONSUME,
		OP_STOP_MODES
	} op_t;

	typedef enum logic [1:0] {
		POP_PROTO,
		POP_PROTO_RASTER,
		POP_RASTER
	} pop_kind_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic       link_error;
	} cmd_t;

	typedef struct packed {
		logic [3:0] stop_code;
		logic [3:0] resume_code;
		logic [3:0] status_code;
		logic [3:0] superstatus_code;
		logic [6:0] raster_start_code;
		logic [6:0] raster_end_code;
	} cfg_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       read_valid;
		logic       underrun;
		logic       link_error;
		logic [1:0] stop_reason;
		logic       resume_event;
		logic       status_request;
		logic       superstatus_request;
		logic       chunk_done;
		logic       raster_active;
	} res_t;

endpackage

// File: design/srcf_queue.sv
// small register queue used between front and back and for results
// depends on nothing but its parameters
module srcf_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [IW-1:0]    wr_ptr_q;
	logic [IW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == IW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == IW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: design/srcf_front.sv
// front part: takes requests, pairs the two copies of a line byte and classifies them
// depends on srcf_pkg
module srcf_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  logic [2:0]     func,
	input  logic [7:0]     rx_byte,
	input  srcf_pkg::cfg_t cfg,
	input  logic           q_full,
	output logic           full,
	output logic           cmd_push,
	output srcf_pkg::cmd_t cmd
);
	import srcf_pkg::*;

	logic       expect_first_q;
	logic [7:0] held_q;
	logic       accept;

	assign accept   = push && !q_full;
	assign full     = q_full;
	assign cmd_push = accept;

	always_comb begin
		cmd.op         = OP_NOP;
		cmd.data       = rx_byte;
		cmd.link_error = 1'b0;
		unique case (func)
			FN_RECEIVE: begin
				if (!expect_first_q) begin
					cmd.link_error = (rx_byte != held_q);
					if (rx_byte[7:4] == 4'd0) begin
						priority if (rx_byte[3:0] == cfg.stop_code) begin
							cmd.op = OP_STOP;
						end else if (rx_byte[3:0] == cfg.resume_code) begin
							cmd.op = OP_RESUME;
						end else if (rx_byte[3:0] == cfg.status_code) begin
							cmd.op = OP_STATUS;
						end else if (rx_byte[3:0] == cfg.superstatus_code) begin
							cmd.op = OP_SSTATUS;
						end else begin
							cmd.op = OP_INVALID;
						end
					end else begin
						cmd.op = OP_WRITE;
					end
				end
			end
			FN_PROTO_READ:  cmd.op = OP_PROTO_READ;
			FN_RASTER_READ: cmd.op = OP_RASTER_READ;
			FN_CONSUME:     cmd.op = OP_CONSUME;
			FN_STOP_MODES:  cmd.op = OP_STOP_MODES;
			default:        cmd.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_first_q <= 1'b1;
			held_q         <= '0;
		end else if (accept && func == FN_RECEIVE) begin
			expect_first_q <= !expect_first_q;
			if (expect_first_q) begin
				held_q <= rx_byte;
			end
		end
	end

endmodule

// File: design/srcf_back.sv
// back part: carries out classified requests on the byte ring and the mode flags
// depends on srcf_pkg; holds the ring memory
module srcf_back #(
	parameter int FIFO_DEPTH = srcf_pkg::FIFO_DEPTH_DEF,
	parameter int CHUNK_LEN  = srcf_pkg::CHUNK_LEN_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_empty,
	input  srcf_pkg::cmd_t cmd,
	output logic           cmd_pop,
	input  srcf_pkg::cfg_t cfg,
	input  logic           res_full,
	output logic           res_push,
	output srcf_pkg::res_t res
);
	import srcf_pkg::*;

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int CW = (CHUNK_LEN > 1) ? $clog2(CHUNK_LEN) : 1;

	typedef enum logic [1:0] {
		ST_EXEC = 2'b01,
		ST_POP  = 2'b10
	} back_state_t;

	back_state_t state_q, state_d;
	logic [7:0]  mem [FIFO_DEPTH];
	logic [7:0]  rd_data_q;
	logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_next, rd_next;
	logic [CW-1:0] count_q, count_d;
	logic        raster_q, raster_d;
	logic        consume_q, consume_d;
	logic        under_rep_q, under_rep_d;
	logic        chunk_q, chunk_d;
	pop_kind_t   kind_q, kind_d;
	logic        mem_we;
	logic        do_pop;
	logic        ring_empty;

	assign wr_next    = (wr_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
	assign rd_next    = (rd_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
	assign ring_empty = (rd_ptr_q == wr_ptr_q);

	always_comb begin
		state_d     = state_q;
		wr_ptr_d    = wr_ptr_q;
		rd_ptr_d    = rd_ptr_q;
		count_d     = count_q;
		raster_d    = raster_q;
		consume_d   = consume_q;
		under_rep_d = under_rep_q;
		chunk_d     = chunk_q;
		kind_d      = kind_q;
		mem_we      = 1'b0;
		do_pop      = 1'b0;
		cmd_pop     = 1'b0;
		res_push    = 1'b0;
		res         = '0;
		unique case (state_q)
			ST_EXEC: begin
				if (!cmd_empty && !res_full) begin
					cmd_pop        = 1'b1;
					res.link_error = cmd.link_error;
					unique case (cmd.op)
						OP_STOP:    res.stop_reason = STOP_REQ;
						OP_STATUS:  res.status_request = 1'b1;
						OP_SSTATUS: res.superstatus_request = 1'b1;
						OP_INVALID: res.stop_reason = STOP_INVALID;
						OP_RESUME: begin
							raster_d         = 1'b0;
							consume_d        = 1'b0;
							wr_ptr_d         = '0;
							rd_ptr_d         = '0;
							count_d          = '0;
							res.resume_event = 1'b1;
						end
						OP_WRITE: begin
							if (wr_next == rd_ptr_q) begin
								res.stop_reason = STOP_OVERFLOW;
							end else begin
								mem_we   = 1'b1;
								wr_ptr_d = wr_next;
							end
						end
						OP_PROTO_READ: begin
							if (!(raster_q && !consume_q)) begin
								if (ring_empty) begin
									res.underrun = !under_rep_q;
									under_rep_d  = 1'b1;
								end else begin
									do_pop = 1'b1;
									kind_d = raster_q ? POP_PROTO_RASTER : POP_PROTO;
								end
							end
						end
						OP_RASTER_READ: begin
							res.read_data = RASTER_ZERO;
							if (raster_q && !consume_q) begin
								if (ring_empty) begin
									res.underrun = 1'b1;
								end else begin
									do_pop = 1'b1;
									kind_d = POP_RASTER;
								end
							end
						end
						OP_CONSUME: consume_d = 1'b1;
						OP_STOP_MODES: begin
							raster_d  = 1'b0;
							consume_d = 1'b0;
						end
						default: ;
					endcase
					if (do_pop) begin
						rd_ptr_d    = rd_next;
						under_rep_d = 1'b0;
						state_d     = ST_POP;
						if (count_q == CW'(CHUNK_LEN - 1)) begin
							count_d = '0;
							chunk_d = 1'b1;
						end else begin
							count_d = count_q + 1'b1;
							chunk_d = 1'b0;
						end
					end else begin
						res_push = 1'b1;
					end
				end
			end
			ST_POP: begin
				res_push       = 1'b1;
				res.chunk_done = chunk_q;
				state_d        = ST_EXEC;
				unique case (kind_q)
					POP_PROTO_RASTER: begin
						if (rd_data_q == {1'b0, cfg.raster_end_code}) begin
							raster_d = 1'b0;
						end
					end
					POP_PROTO: begin
						if (rd_data_q == {1'b0, cfg.raster_start_code}) begin
							raster_d  = 1'b1;
							consume_d = 1'b0;
						end else begin
							res.read_data  = rd_data_q;
							res.read_valid = 1'b1;
						end
					end
					POP_RASTER: begin
						res.read_data = RASTER_ZERO;
						priority if (rd_data_q[7]) begin
							res.read_data  = rd_data_q;
							res.read_valid = 1'b1;
						end else if (rd_data_q == {1'b0, cfg.raster_end_code}) begin
							raster_d = 1'b0;
						end else begin
							res.stop_reason = STOP_INVALID;
						end
					end
					default: ;
				endcase
			end
			default: state_d = ST_EXEC;
		endcase
		res.raster_active = raster_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_ptr_q] <= cmd.data;
		end
		if (do_pop) begin
			rd_data_q <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_EXEC;
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			count_q     <= '0;
			raster_q    <= 1'b0;
			consume_q   <= 1'b0;
			under_rep_q <= 1'b0;
			chunk_q     <= 1'b0;
			kind_q      <= POP_PROTO;
		end else begin
			state_q     <= state_d;
			wr_ptr_q    <= wr_ptr_d;
			rd_ptr_q    <= rd_ptr_d;
			count_q     <= count_d;
			raster_q    <= raster_d;
			consume_q   <= consume_d;
			under_rep_q <= under_rep_d;
			chunk_q     <= chunk_d;
			kind_q      <= kind_d;
		end
	end

endmodule

// File: design/serial_rx_command_fifo.sv
// channel   | direction | handshake          | payload
// request   | in        | push / full        | func, rx_byte
// result    | out       | empty / pop        | read_data .. raster_active
// config    | in        | psel/penable/pready| paddr, pwdata, prdata
//
// the front takes one request per cycle into a two-entry command queue while that queue is not full
// the back carries out one request per cycle while the result queue has room; a pop moves
// from ST_EXEC to ST_POP for the registered ring memory read, and ST_POP takes no new request
// a result reaches the ports from the registered result queue; a pop first passes through rd_data_q
// results wait in a two-entry queue; when it is full the back holds, then the front
// no reset pass: the ring memory is only read where it was written
// top level of the serial receive command fifo; depends on srcf_pkg, srcf_front,
// srcf_queue and srcf_back
module serial_rx_command_fifo #(
	parameter int FIFO_DEPTH = srcf_pkg::FIFO_DEPTH_DEF,
	parameter int CHUNK_LEN  = srcf_pkg::CHUNK_LEN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [srcf_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	input  logic                            push,
	output logic                            full,
	input  logic [2:0]                      func,
	input  logic [7:0]                      rx_byte,
	output logic                            empty,
	input  logic                            pop,
	output logic [7:0]                      read_data,
	output logic                            read_valid,
	output logic                            underrun,
	output logic                            link_error,
	output logic [1:0]                      stop_reason,
	output logic                            resume_event,
	output logic                            status_request,
	output logic                            superstatus_request,
	output logic                            chunk_done,
	output logic                            raster_active
);
	import srcf_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     cfg_wr;
	cmd_t     cmd_in, cmd_out;
	logic     cmd_push, cmd_pop, cmdq_full, cmdq_empty;
	res_t     res_in, res_out;
	logic     res_push, resq_full;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_STOP:    prdata = {28'd0, cfg_q.stop_code};
			REG_RESUME:  prdata = {28'd0, cfg_q.resume_code};
			REG_STATUS:  prdata = {28'd0, cfg_q.status_code};
			REG_SSTATUS: prdata = {28'd0, cfg_q.superstatus_code};
			REG_RSTART:  prdata = {25'd0, cfg_q.raster_start_code};
			REG_REND:    prdata = {25'd0, cfg_q.raster_end_code};
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stop_code         <= RST_STOP_CODE;
			cfg_q.resume_code       <= RST_RESUME_CODE;
			cfg_q.status_code       <= RST_STATUS_CODE;
			cfg_q.superstatus_code  <= RST_SSTATUS_CODE;
			cfg_q.raster_start_code <= RST_RSTART_CODE;
			cfg_q.raster_end_code   <= RST_REND_CODE;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_STOP:    cfg_q.stop_code         <= pwdata[3:0];
				REG_RESUME:  cfg_q.resume_code       <= pwdata[3:0];
				REG_STATUS:  cfg_q.status_code       <= pwdata[3:0];
				REG_SSTATUS: cfg_q.superstatus_code  <= pwdata[3:0];
				REG_RSTART:  cfg_q.raster_start_code <= pwdata[6:0];
				REG_REND:    cfg_q.raster_end_code   <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	srcf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.func     (func),
		.rx_byte  (rx_byte),
		.cfg      (cfg_q),
		.q_full   (cmdq_full),
		.full     (full),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	srcf_queue #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (Q_DEPTH)
	) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.full   (cmdq_full),
		.empty  (cmdq_empty)
	);

	srcf_back #(
		.FIFO_DEPTH (FIFO_DEPTH),
		.CHUNK_LEN  (CHUNK_LEN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmdq_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.cfg       (cfg_q),
		.res_full  (resq_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	srcf_queue #(
		.WIDTH ($bits(res_t)),
		.DEPTH (Q_DEPTH)
	) u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.pop    (pop),
		.rdata  (res_out),
		.full   (resq_full),
		.empty  (empty)
	);

	assign read_data           = res_out.read_data;
	assign read_valid          = res_out.read_valid;
	assign underrun            = res_out.underrun;
	assign link_error          = res_out.link_error;
	assign stop_reason         = res_out.stop_reason;
	assign resume_event        = res_out.resume_event;
	assign status_request      = res_out.status_request;
	assign superstatus_request = res_out.superstatus_request;
	assign chunk_done          = res_out.chunk_done;
	assign raster_active       = res_out.raster_active;

	a_cmd_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !cmdq_full)
		else $error("command queue written while full");

	a_cmd_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmdq_empty)
		else $error("command taken from an empty queue");

	a_res_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !resq_full)
		else $error("result lost on a full result queue");

	a_valid_not_both: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res_in.read_valid) |-> (res_in.stop_reason == STOP_NONE
			&& !res_in.underrun && !res_in.link_error))
		else $error("delivered byte carries an error flag");

endmodule

// File: tb/serial_rx_command_fifo_tb.sv
// testbench for serial_rx_command_fifo: predicts each result from the request stream and checks it
// directed and randomised requests under several register settings; depends on srcf_pkg and the rtl
`timescale 1ns / 100ps

module serial_rx_command_fifo_tb;
	import srcf_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int RING_SIZE   = FIFO_DEPTH_DEF;
	localparam int CHUNK_SIZE  = CHUNK_LEN_DEF;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;
	logic                  push;
	logic                  full;
	logic [2:0]            func;
	logic [7:0]            rx_byte;
	logic                  empty;
	logic                  pop;
	res_t                  res;

	serial_rx_command_fifo dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.psel                (psel),
		.penable             (penable),
		.pwrite              (pwrite),
		.paddr               (paddr),
		.pwdata              (pwdata),
		.prdata              (prdata),
		.pready              (pready),
		.push                (push),
		.full                (full),
		.func                (func),
		.rx_byte             (rx_byte),
		.empty               (empty),
		.pop                 (pop),
		.read_data           (res.read_data),
		.read_valid          (res.read_valid),
		.underrun            (res.underrun),
		.link_error          (res.link_error),
		.stop_reason         (res.stop_reason),
		.resume_event        (res.resume_event),
		.status_request      (res.status_request),
		.superstatus_request (res.superstatus_request),
		.chunk_done          (res.chunk_done),
		.raster_active       (res.raster_active)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [7:0] ring [RING_SIZE];
	int         wr_ptr;
	int         rd_ptr;
	logic       want_first;
	logic [7:0] held_byte;
	logic       model_raster;
	logic       consuming;
	int         pop_count;
	logic       underrun_seen;
	cfg_t       model_cfg;

	res_t cmd_outcomes[$];
	int   err_count     = 0;
	int   requests_sent = 0;
	int   src_idle_pct  = 30;
	int   sink_idle_pct = 30;
	int   hold_off      = 0;

	function automatic int pick_gap(int pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	function automatic logic [7:0] take_byte(inout res_t r);
		logic [7:0] b;
		b = ring[rd_ptr];
		rd_ptr = (rd_ptr + 1) % RING_SIZE;
		underrun_seen = 1'b0;
		pop_count++;
		if (pop_count >= CHUNK_SIZE) begin
			pop_count = 0;
			r.chunk_done = 1'b1;
		end
		return b;
	endfunction

	function automatic res_t predict_cmd_outcome(logic [2:0] f, logic [7:0] b);
		res_t       r;
		logic [7:0] got;
		r = '0;
		case (f)
			FN_RECEIVE: begin
				if (want_first) begin
					want_first = 1'b0;
					held_byte = b;
				end else begin
					want_first = 1'b1;
					r.link_error = (b != held_byte);
					if (b < 8'd16) begin
						if (b[3:0] == model_cfg.stop_code) begin
							r.stop_reason = STOP_REQ;
						end else if (b[3:0] == model_cfg.resume_code) begin
							model_raster = 1'b0;
							consuming = 1'b0;
							wr_ptr = 0;
							rd_ptr = 0;
							pop_count = 0;
							r.resume_event = 1'b1;
						end else if (b[3:0] == model_cfg.status_code) begin
							r.status_request = 1'b1;
						end else if (b[3:0] == model_cfg.superstatus_code) begin
							r.superstatus_request = 1'b1;
						end else begin
							r.stop_reason = STOP_INVALID;
						end
					end else if ((wr_ptr + 1) % RING_SIZE == rd_ptr) begin
						r.stop_reason = STOP_OVERFLOW;
					end else begin
						ring[wr_ptr] = b;
						wr_ptr = (wr_ptr + 1) % RING_SIZE;
					end
				end
			end
			FN_PROTO_READ: begin
				if (!model_raster || consuming) begin
					if (rd_ptr == wr_ptr) begin
						if (!underrun_seen) begin
							r.underrun = 1'b1;
							underrun_seen = 1'b1;
						end
					end else begin
						got = take_byte(r);
						if (model_raster) begin
							if (got == {1'b0, model_cfg.raster_end_code})
								model_raster = 1'b0;
						end else if (got == {1'b0, model_cfg.raster_start_code}) begin
							model_raster = 1'b1;
							consuming = 1'b0;
						end else begin
							r.read_data = got;
							r.read_valid = 1'b1;
						end
					end
				end
			end
			FN_RASTER_READ: begin
				r.read_data = RASTER_ZERO;
				if (model_raster && !consuming) begin
					if (rd_ptr == wr_ptr) begin
						r.underrun = 1'b1;
					end else begin
						got = take_byte(r);
						if (got[7]) begin
							r.read_data = got;
							r.read_valid = 1'b1;
						end else if (got == {1'b0, model_cfg.raster_end_code}) begin
							model_raster = 1'b0;
						end else begin
							r.stop_reason = STOP_INVALID;
						end
					end
				end
			end
			FN_CONSUME: consuming = 1'b1;
			FN_STOP_MODES: begin
				model_raster = 1'b0;
				consuming = 1'b0;
			end
			default: ;
		endcase
		r.raster_active = model_raster;
		return r;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s expected %0d got %0d", name, want, got);
			err_count++;
		end
	endfunction

	// result checker
	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && pop && !empty) begin
			if (cmd_outcomes.size() == 0) begin
				$error("result arrived with no request outstanding");
				err_count++;
			end else begin
				want = cmd_outcomes.pop_front();
				check_field("read_data", want.read_data, res.read_data);
				check_field("read_valid", want.read_valid, res.read_valid);
				check_field("underrun", want.underrun, res.underrun);
				check_field("link_error", want.link_error, res.link_error);
				check_field("stop_reason", want.stop_reason, res.stop_reason);
				check_field("resume_event", want.resume_event, res.resume_event);
				check_field("status_request", want.status_request, res.status_request);
				check_field("superstatus_request", want.superstatus_request,
					res.superstatus_request);
				check_field("chunk_done", want.chunk_done, res.chunk_done);
				check_field("raster_active", want.raster_active, res.raster_active);
			end
		end
	end

	// result side: random stalls plus a long hold-off when a test sets one
	initial begin : result_sink
		int stall;
		stall = 0;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				pop = 1'b0;
				hold_off--;
			end else if (stall > 0) begin
				pop = 1'b0;
				stall--;
			end else begin
				pop = 1'b1;
				stall = pick_gap(sink_idle_pct);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (push && !full) || (pop && !empty))
				quiet = 0;
			else
				quiet++;
		end
		$display("simulation failed");
		$finish;
	end

	task automatic send_request(input logic [2:0] f, input logic [7:0] b);
		int gap;
		gap = pick_gap(src_idle_pct);
		if (gap > 0) begin
			push = 1'b0;
			repeat (gap) @(negedge clk);
		end
		push = 1'b1;
		func = f;
		rx_byte = b;
		@(posedge clk);
		while (full) @(posedge clk);
		cmd_outcomes.push_back(predict_cmd_outcome(f, b));
		requests_sent++;
		@(negedge clk);
		push = 1'b0;
	endtask

	task automatic send_line_pair(input logic [7:0] first, input logic [7:0] second);
		send_request(FN_RECEIVE, first);
		send_request(FN_RECEIVE, second);
	endtask

	task automatic send_line_byte(input logic [7:0] b);
		send_line_pair(b, b);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		push = 1'b0;
		while (cmd_outcomes.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		logic [31:0] mask;
		wait_drained();
		mask = (idx == REG_RSTART || idx == REG_REND) ? 32'd127 : 32'd15;
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = CFG_ADDR_W'(4 * int'(idx));
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_STOP:    model_cfg.stop_code = value[3:0];
			REG_RESUME:  model_cfg.resume_code = value[3:0];
			REG_STATUS:  model_cfg.status_code = value[3:0];
			REG_SSTATUS: model_cfg.superstatus_code = value[3:0];
			REG_RSTART:  model_cfg.raster_start_code = value[6:0];
			REG_REND:    model_cfg.raster_end_code = value[6:0];
			default: ;
		endcase
		// read back
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		check_field("prdata", value & mask, prdata);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic write_codes(input logic [3:0] stop_c, input logic [3:0] resume_c,
		input logic [3:0] status_c, input logic [3:0] sstatus_c,
		input logic [6:0] start_c, input logic [6:0] end_c);
		write_reg(REG_STOP, 32'(stop_c));
		write_reg(REG_RESUME, 32'(resume_c));
		write_reg(REG_STATUS, 32'(status_c));
		write_reg(REG_SSTATUS, 32'(sstatus_c));
		write_reg(REG_RSTART, 32'(start_c));
		write_reg(REG_REND, 32'(end_c));
	endtask

	task automatic random_traffic(input int n);
		int         stop_at;
		int         r;
		int         k;
		logic [7:0] b;
		stop_at = requests_sent + n;
		while (requests_sent < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 38) begin
				k = $urandom_range(0, 9);
				if (k < 6)
					b = 8'($urandom_range(16, 255));
				else if (k < 7)
					b = {1'b0, model_cfg.raster_start_code};
				else if (k < 8)
					b = {1'b0, model_cfg.raster_end_code};
				else
					b = 8'($urandom_range(128, 255));
				if ($urandom_range(0, 19) == 0)
					send_line_pair(b, 8'($urandom));
				else
					send_line_byte(b);
			end else if (r < 44) begin
				send_line_byte(8'($urandom_range(0, 15)));
			end else if (r < 46) begin
				send_request(FN_RECEIVE, 8'($urandom));
			end else if (r < 62) begin
				send_request(FN_PROTO_READ, 8'($urandom));
			end else if (r < 74) begin
				send_request(FN_RASTER_READ, 8'($urandom));
			end else if (r < 78) begin
				send_request(FN_CONSUME, 8'($urandom));
			end else if (r < 81) begin
				send_request(FN_STOP_MODES, 8'($urandom));
			end else if (r < 83) begin
				send_request(3'($urandom_range(int'(FN_STOP_MODES) + 1, 7)), 8'($urandom));
			end else begin
				// raster line: start marker, pixels, end marker
				send_line_byte({1'b0, model_cfg.raster_start_code});
				send_request(FN_PROTO_READ, 8'($urandom));
				repeat ($urandom_range(1, 6)) begin
					send_line_byte(8'($urandom_range(128, 255)));
					send_request(FN_RASTER_READ, 8'($urandom));
				end
				if ($urandom_range(0, 1)) begin
					send_request(FN_CONSUME, 8'($urandom));
					send_line_byte({1'b0, model_cfg.raster_end_code});
					send_request(FN_PROTO_READ, 8'($urandom));
				end else begin
					send_line_byte({1'b0, model_cfg.raster_end_code});
					send_request(FN_RASTER_READ, 8'($urandom));
				end
			end
		end
	endtask

	task automatic test_basic_requests();
		send_line_byte(8'd0);
		send_line_byte(8'(RST_STOP_CODE));
		send_line_byte(8'(RST_STATUS_CODE));
		send_line_byte(8'(RST_SSTATUS_CODE));
		send_line_byte(8'd15);
		send_line_pair(8'h55, 8'hAA);
		send_line_byte(8'(RST_RESUME_CODE));
		send_request(FN_PROTO_READ, 8'hFF);
		send_line_byte(8'd255);
		send_request(FN_PROTO_READ, 8'h00);
		send_request(FN_PROTO_READ, 8'h00);
		send_request(FN_PROTO_READ, 8'h00);
		send_request(FN_RASTER_READ, 8'h00);
		send_line_byte({1'b0, RST_RSTART_CODE});
		send_request(FN_PROTO_READ, 8'h00);
		send_request(FN_RASTER_READ, 8'h00);
		send_request(FN_RASTER_READ, 8'h00);
		send_line_byte(8'd200);
		send_request(FN_RASTER_READ, 8'h00);
		send_line_byte(8'd50);
		send_request(FN_RASTER_READ, 8'h00);
		send_request(FN_PROTO_READ, 8'h00);
		send_request(FN_CONSUME, 8'h00);
		send_request(FN_RASTER_READ, 8'h00);
		send_request(FN_PROTO_READ, 8'h00);
		send_line_byte({1'b0, RST_REND_CODE});
		send_request(FN_PROTO_READ, 8'h00);
		send_request(FN_STOP_MODES, 8'h00);
		for (int k = int'(FN_STOP_MODES) + 1; k < 8; k++)
			send_request(3'(k), 8'hFF);
	endtask

	task automatic test_overflow_and_drain();
		logic [7:0] b;
		send_request(FN_STOP_MODES, 8'h00);
		send_line_byte({4'd0, model_cfg.resume_code});
		repeat (RING_SIZE + 1) begin
			b = 8'($urandom_range(16, 255));
			while (b == {1'b0, model_cfg.raster_start_code})
				b = 8'($urandom_range(16, 255));
			send_line_byte(b);
		end
		repeat (RING_SIZE) send_request(FN_PROTO_READ, 8'($urandom));
	endtask

	task automatic test_sink_hold_off();
		src_idle_pct = 0;
		hold_off = 150;
		random_traffic(24);
		src_idle_pct = 30;
	endtask

	task automatic test_source_pause();
		random_traffic(40);
		wait_drained();
		random_traffic(40);
	endtask

	task automatic test_extreme_codes();
		// status shares the stop code and superstatus the resume code
		write_codes(4'd0, 4'd15, 4'd0, 4'd15, 7'd127, 7'd16);
		send_line_byte(8'd0);
		send_line_byte(8'd15);
		send_line_byte(8'd127);
		send_request(FN_PROTO_READ, 8'h00);
		send_line_byte(8'd255);
		send_request(FN_RASTER_READ, 8'h00);
		send_line_byte(8'd16);
		send_request(FN_RASTER_READ, 8'h00);
		random_traffic(180);
		write_codes(4'd15, 4'd0, 4'd7, 4'd7, 7'd16, 7'd127);
		send_line_byte(8'd7);
		send_line_byte(8'd15);
		random_traffic(180);
	endtask

	task automatic test_random_codes();
		repeat (2) begin
			write_codes(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
				4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
				7'($urandom_range(16, 127)), 7'($urandom_range(16, 127)));
			src_idle_pct = $urandom_range(0, 2) * 25;
			sink_idle_pct = $urandom_range(0, 2) * 25;
			random_traffic(150);
		end
		src_idle_pct = 30;
		sink_idle_pct = 30;
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		push = 1'b0;
		func = FN_RECEIVE;
		rx_byte = 8'h00;
		wr_ptr = 0;
		rd_ptr = 0;
		want_first = 1'b1;
		held_byte = 8'h00;
		model_raster = 1'b0;
		consuming = 1'b0;
		pop_count = 0;
		underrun_seen = 1'b0;
		model_cfg.stop_code = RST_STOP_CODE;
		model_cfg.resume_code = RST_RESUME_CODE;
		model_cfg.status_code = RST_STATUS_CODE;
		model_cfg.superstatus_code = RST_SSTATUS_CODE;
		model_cfg.raster_start_code = RST_RSTART_CODE;
		model_cfg.raster_end_code = RST_REND_CODE;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_basic_requests();
		random_traffic(120);
		test_sink_hold_off();
		test_source_pause();
		test_overflow_and_drain();
		test_extreme_codes();
		test_random_codes();
		write_codes(RST_STOP_CODE, RST_RESUME_CODE, RST_STATUS_CODE, RST_SSTATUS_CODE,
			RST_RSTART_CODE, RST_REND_CODE);
		src_idle_pct = 0;
		sink_idle_pct = 0;
		random_traffic(60);

		wait_drained();
		repeat (8) @(posedge clk);
		if (err_count == 0 && cmd_outcomes.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
